// ===== rtl/sct_pkg.sv =====
`default_nettype none
package sct_pkg;

  localparam int CHAR_W   = 8;
  localparam int MODE_W   = 3;
  localparam int TK_W     = 3;
  localparam int RES_MAX  = 4;
  localparam int CNT_W    = $clog2(RES_MAX + 1);
  localparam int QDEPTH   = 8;
  localparam int QAW      = $clog2(QDEPTH);
  localparam int QCW      = $clog2(QDEPTH + 1);

  // lexer modes
  localparam logic [MODE_W-1:0] MODE_NORMAL = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SQUOTE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DQUOTE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ESCAPE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DIGIT  = 3'd4;

  // token types
  localparam logic [TK_W-1:0] TK_STRING = 3'd0;
  localparam logic [TK_W-1:0] TK_REDIR  = 3'd1;
  localparam logic [TK_W-1:0] TK_APPEND = 3'd2;
  localparam logic [TK_W-1:0] TK_FD     = 3'd3;
  localparam logic [TK_W-1:0] TK_PIPE   = 3'd4;
  localparam logic [TK_W-1:0] TK_AMP    = 3'd5;

  // result kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DQ    = 8'h22;
  localparam logic [CHAR_W-1:0] CH_AMP   = 8'h26;
  localparam logic [CHAR_W-1:0] CH_SQ    = 8'h27;
  localparam logic [CHAR_W-1:0] CH_D0    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_D9    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_BSL   = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_PIPE  = 8'h7C;

  typedef struct packed {
    logic              kind;
    logic [TK_W-1:0]   token_kind;
    logic [CHAR_W-1:0] char_out;
    logic              last;
  } sct_res_t;

  typedef struct packed {
    logic [CNT_W-1:0]            cnt;
    sct_res_t [RES_MAX-1:0]      ent;
  } sct_push_t;

  function automatic sct_res_t mk_res(logic kind, logic [TK_W-1:0] tk,
                                      logic [CHAR_W-1:0] ch);
    sct_res_t r;
    r.kind       = kind;
    r.token_kind = tk;
    r.char_out   = ch;
    r.last       = 1'b0;
    return r;
  endfunction

  // append one result, dropping it once the beat list is full
  function automatic sct_push_t push_res(sct_push_t p, sct_res_t e);
    if (p.cnt < CNT_W'(RES_MAX)) begin
      p.ent[p.cnt[$clog2(RES_MAX)-1:0]] = e;
      p.cnt = p.cnt + CNT_W'(1);
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/shell_command_tokenizer_unit.sv =====
// path: a byte waits in the input register, then its results enter the buffer
// throughput: one byte per cycle while the result buffer keeps four free slots;
//   results drain one per cycle when not stalled; multi-result bytes slow intake
// reset: synchronous, active low; clears lexer state, input stage and buffer
`default_nettype none
module shell_command_tokenizer_unit
  import sct_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CHAR_W-1:0] in_char_in,
  input  wire logic              in_line_end,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_kind,
  output logic [TK_W-1:0]        out_token_kind,
  output logic [CHAR_W-1:0]      out_char_out,
  output logic                   out_last
);

  logic              iv_r, iv_nxt;
  logic [CHAR_W-1:0] ic_r;
  logic              ie_r;
  logic              room;
  logic              proc;
  logic              acc;
  sct_push_t         push;
  sct_res_t          rd;

  assign in_stall = iv_r & ~room;
  assign acc      = in_valid & ~in_stall;
  assign proc     = iv_r & room;
  assign iv_nxt   = acc | (iv_r & ~proc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else begin
      iv_r <= iv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      ic_r <= in_char_in;
      ie_r <= in_line_end;
    end
  end

  sct_lexer u_lexer (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (proc),
    .c     (ic_r),
    .eol   (ie_r),
    .push  (push)
  );

  sct_rbuf u_rbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (proc),
    .wr       (push),
    .room     (room),
    .rd_valid (out_valid),
    .rd_stall (out_stall),
    .rd       (rd)
  );

  assign out_kind       = rd.kind;
  assign out_token_kind = rd.token_kind;
  assign out_char_out   = rd.char_out;
  assign out_last       = rd.last;

endmodule
`default_nettype wire

// ===== rtl/sct_lexer.sv =====
`default_nettype none
module sct_lexer
  import sct_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [CHAR_W-1:0] c,
  input  wire logic              eol,
  output sct_push_t              push
);

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [MODE_W-1:0] ret_r, ret_nxt;
  logic              gt_r, gt_nxt;
  logic              ne_r, ne_nxt;
  logic              st_r, st_nxt;

  always_comb begin
    sct_push_t         p;
    logic [MODE_W-1:0] m;
    logic [MODE_W-1:0] rm;
    logic              gt;
    logic              ne;
    logic              st;
    logic              consumed;
    logic              do_norm;
    logic              is_dig;

    p        = '0;
    m        = mode_r;
    rm       = ret_r;
    gt       = gt_r;
    ne       = ne_r;
    st       = st_r;
    consumed = 1'b0;
    do_norm  = 1'b0;
    is_dig   = (c >= CH_D0) && (c <= CH_D9);

    if (!st && (c == CH_SPACE || c == CH_TAB)) begin
      // leading blank dropped
    end else begin
      st = 1'b1;
      if (gt) begin
        gt = 1'b0;
        if (c == CH_GT) begin
          p = push_res(p, mk_res(KIND_END, TK_APPEND, CH_NUL));
          ne = 1'b0;
          consumed = 1'b1;
        end else begin
          p = push_res(p, mk_res(KIND_END, TK_REDIR, CH_NUL));
          ne = 1'b0;
        end
      end
      if (!consumed) begin
        case (m)
          MODE_SQUOTE: begin
            if (c == CH_SQ) begin
              rm = m;
              m  = MODE_NORMAL;
            end else begin
              p  = push_res(p, mk_res(KIND_CHAR, TK_STRING, c));
              ne = 1'b1;
            end
          end
          MODE_DQUOTE: begin
            if (c == CH_DQ) begin
              rm = m;
              m  = MODE_NORMAL;
            end else if (c == CH_BSL) begin
              rm = m;
              m  = MODE_ESCAPE;
            end else begin
              p  = push_res(p, mk_res(KIND_CHAR, TK_STRING, c));
              ne = 1'b1;
            end
          end
          MODE_ESCAPE: begin
            if (c != CH_NUL) begin
              p  = push_res(p, mk_res(KIND_CHAR, TK_STRING, c));
              ne = 1'b1;
            end
            m = (rm == MODE_ESCAPE) ? MODE_NORMAL : rm;
          end
          MODE_DIGIT: begin
            if (is_dig) begin
              p  = push_res(p, mk_res(KIND_CHAR, TK_STRING, c));
              ne = 1'b1;
            end else begin
              if (c == CH_GT) begin
                p  = push_res(p, mk_res(KIND_END, TK_FD, CH_NUL));
                ne = 1'b0;
              end
              rm      = m;
              m       = MODE_NORMAL;
              do_norm = 1'b1;
            end
          end
          default: begin
            m       = MODE_NORMAL;
            do_norm = 1'b1;
          end
        endcase
      end

      if (do_norm) begin
        if (c == CH_NUL || c == CH_NL || c == CH_SPACE) begin
          if (ne) begin
            p  = push_res(p, mk_res(KIND_END, TK_STRING, CH_NUL));
            ne = 1'b0;
          end
        end else if (c == CH_SQ) begin
          rm = m;
          m  = MODE_SQUOTE;
        end else if (c == CH_DQ) begin
          rm = m;
          m  = MODE_DQUOTE;
        end else if (c == CH_BSL) begin
          rm = m;
          m  = MODE_ESCAPE;
        end else if (c == CH_GT) begin
          if (ne) begin
            p  = push_res(p, mk_res(KIND_END, TK_STRING, CH_NUL));
            ne = 1'b0;
          end
          gt = 1'b1;
        end else if (c == CH_PIPE) begin
          if (ne) begin
            p  = push_res(p, mk_res(KIND_END, TK_STRING, CH_NUL));
            ne = 1'b0;
          end
          p  = push_res(p, mk_res(KIND_END, TK_PIPE, CH_NUL));
          ne = 1'b0;
        end else if (c == CH_AMP) begin
          p  = push_res(p, mk_res(KIND_END, TK_AMP, CH_NUL));
          ne = 1'b0;
        end else if (is_dig) begin
          rm = m;
          m  = MODE_DIGIT;
          p  = push_res(p, mk_res(KIND_CHAR, TK_STRING, c));
          ne = 1'b1;
        end else begin
          p  = push_res(p, mk_res(KIND_CHAR, TK_STRING, c));
          ne = 1'b1;
        end
      end
    end

    // end of line flushes everything, whatever the mode
    if (eol) begin
      if (gt) begin
        gt = 1'b0;
        p  = push_res(p, mk_res(KIND_END, TK_REDIR, CH_NUL));
        ne = 1'b0;
      end
      if (ne) begin
        p  = push_res(p, mk_res(KIND_END, TK_STRING, CH_NUL));
        ne = 1'b0;
      end
      m  = MODE_NORMAL;
      rm = MODE_NORMAL;
      st = 1'b0;
    end

    if (p.cnt != '0) begin
      p.ent[$clog2(RES_MAX)'(p.cnt - CNT_W'(1))].last = 1'b1;
    end

    push     = p;
    mode_nxt = m;
    ret_nxt  = rm;
    gt_nxt   = gt;
    ne_nxt   = ne;
    st_nxt   = st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      ret_r  <= MODE_NORMAL;
      gt_r   <= 1'b0;
      ne_r   <= 1'b0;
      st_r   <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt;
      ret_r  <= ret_nxt;
      gt_r   <= gt_nxt;
      ne_r   <= ne_nxt;
      st_r   <= st_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sct_rbuf.sv =====
`default_nettype none
module sct_rbuf
  import sct_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       wr_en,
  input  wire sct_push_t  wr,
  output logic            room,
  output logic            rd_valid,
  input  wire logic       rd_stall,
  output sct_res_t        rd
);

  sct_res_t       q_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           pop;
  logic [QCW-1:0] add;

  // room for a whole item's worth of results
  assign room     = (cnt_r <= QCW'(QDEPTH - RES_MAX));
  assign rd_valid = (cnt_r != '0);
  assign rd       = q_r[rp_r];
  assign pop      = rd_valid & ~rd_stall;
  assign add      = wr_en ? QCW'(wr.cnt) : '0;

  always_comb begin
    wp_nxt  = wp_r + QAW'(add);
    rp_nxt  = pop ? rp_r + QAW'(1) : rp_r;
    cnt_nxt = cnt_r + add - (pop ? QCW'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_MAX; i++) begin
      if (wr_en && (CNT_W'(i) < wr.cnt)) begin
        q_r[wp_r + QAW'(i)] <= wr.ent[i];
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sct_checker.sv =====
`default_nettype none
module sct_checker
  import sct_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic              out_kind,
  input wire logic [TK_W-1:0]   out_token_kind,
  input wire logic [CHAR_W-1:0] out_char_out,
  input wire logic              out_last
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind)
      && $stable(out_token_kind) && $stable(out_char_out) && $stable(out_last))
    else $error("result beat changed under stall");

  // token end carries no byte
  a_end_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_END |-> out_char_out == CH_NUL)
    else $error("token end with nonzero byte");

  // token character carries no type
  a_char_no_tk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_CHAR |-> out_token_kind == TK_STRING)
    else $error("token character with a type");

  a_tk_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_token_kind <= TK_AMP)
    else $error("token type out of range");

  // buffer is empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind shell_command_tokenizer_unit sct_checker u_sct_checker (.*);
`default_nettype wire
